@@ hdl/rbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg: shared definitions for the RGBA 2x2 box downscaler
// Pixel layout, channel widths, register limits and register indexes.
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int CHANNELS   = 4;
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = CHANNELS * CHAN_W;
   // Sum of two channel bytes.
   localparam int PAIR_W     = CHAN_W + 1;
   localparam int PAIR_ROW_W = CHANNELS * PAIR_W;

   localparam int CFG_W      = 13;
   localparam int CSR_ADDR_W = 1;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int HEIGHT_MAX        = 4096;
   localparam int ROW_W             = 12;
   localparam int HGT_W             = 13;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;
   localparam int DIM_MIN           = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

endpackage
`default_nettype wire

@@ hdl/rgba_2x2_box_downscaler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_2x2_box_downscaler: 2x2 box filter with half-size output
// Averages each 2x2 block of an RGBA raster stream per channel (floor of the
// sum over four) and marks the last output pixel of the frame with tlast.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  req_*     in         tdata: red[7:0] green[15:8] blue[23:16] alpha[31:24]
//  rsp_*     out        tdata: as req_*, tlast: last output pixel of frame
//  csr_*     in         write only: index 0 frame_width, index 1 frame_height
//
//  One pixel is accepted per clock while req_tready is high. A result passes
//  from the beat that completes its block through the stage register, then
//  the output register; the line store read is registered beside the stage register.
//  A stalled rsp_* side holds req_tready low only once both the stage
//  register and the output register hold a result.
//  Reset is synchronous; the line store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module rgba_2x2_box_downscaler
   import rbd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   input  wire logic [PIXEL_W-1:0]    req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic [PIXEL_W-1:0]         rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CFG_W-1:0]      csr_wdata
);

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
   localparam int CLAMP_W    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W     = COL_W - 1;
   localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   // Configuration, stored already clamped.
   logic [DIM_W-1:0]      width_ff, width_in;
   logic [HGT_W-1:0]      height_ff, height_in;

   // Raster position of the next pixel.
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;

   logic [PIXEL_W-1:0]    left_ff;

   logic                  s1_valid_ff;
   logic                  s1_emit_ff;
   logic                  s1_last_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic [PAIR_ROW_W-1:0] s1_pair_ff;
   logic [PAIR_ROW_W-1:0] line_rd_ff;

   logic                  rsp_valid_ff;
   logic [PIXEL_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff;

   logic [PAIR_ROW_W-1:0] line_mem [LINE_DEPTH];

   logic                  accept;
   logic                  out_free;
   logic                  s1_move;
   logic [DIM_W-1:0]      even_width;
   logic [HGT_W-1:0]      even_height;
   logic [DIM_W-1:0]      col_ext;
   logic [DIM_W-1:0]      col_next;
   logic [HGT_W-1:0]      row_ext;
   logic [HGT_W-1:0]      row_next;
   logic                  in_block;
   logic                  block_last;
   logic [PAIR_ROW_W-1:0] pair_in;
   logic [CLAMP_W-1:0]    cfg_ext;
   logic [HGT_W-1:0]      cfg_hgt;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // Position decode and counter update
   // ------------------------------------------------------------------------
   assign even_width  = {width_ff[DIM_W-1:1], 1'b0};
   assign even_height = {height_ff[HGT_W-1:1], 1'b0};
   assign col_ext     = DIM_W'(col_ff);
   assign row_ext     = HGT_W'(row_ff);
   assign col_next    = col_ext + DIM_W'(1);
   assign row_next    = row_ext + HGT_W'(1);
   assign in_block    = (col_ext < even_width) && (row_ext < even_height);
   assign block_last  = (col_ext == even_width - DIM_W'(1))
                        && (row_ext == even_height - HGT_W'(1));

   always_comb begin
      col_in = col_next[COL_W-1:0];
      row_in = row_ff;
      if (col_next >= width_ff) begin
         col_in = '0;
         if (row_next >= height_ff) begin
            row_in = '0;
         end else begin
            row_in = row_next[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   assign cfg_ext = CLAMP_W'(csr_wdata);
   assign cfg_hgt = HGT_W'(csr_wdata);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH: begin
               if (cfg_ext < CLAMP_W'(DIM_MIN)) begin
                  width_in = DIM_W'(DIM_MIN);
               end else if (cfg_ext > CLAMP_W'(MAX_WIDTH)) begin
                  width_in = DIM_W'(MAX_WIDTH);
               end else begin
                  width_in = DIM_W'(cfg_ext);
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (cfg_hgt < HGT_W'(DIM_MIN)) begin
                  height_in = HGT_W'(DIM_MIN);
               end else if (cfg_hgt > HGT_W'(HEIGHT_MAX)) begin
                  height_in = HGT_W'(HEIGHT_MAX);
               end else begin
                  height_in = cfg_hgt;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(WIDTH_INIT);
         height_ff <= HGT_W'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ------------------------------------------------------------------------
   // Horizontal pair: left pixel hold and pair sums
   // ------------------------------------------------------------------------
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         pair_in[c*PAIR_W +: PAIR_W] = PAIR_W'(left_ff[c*CHAN_W +: CHAN_W])
                                     + PAIR_W'(req_tdata[c*CHAN_W +: CHAN_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (accept && in_block && !col_ff[0]) begin
         left_ff <= req_tdata;
      end
   end

   // ------------------------------------------------------------------------
   // Stage register: one pair sum per right-hand pixel of a block
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= accept && in_block && col_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= row_ff[0];
         s1_last_ff <= block_last;
         s1_addr_ff <= col_ff[COL_W-1:1];
         s1_pair_ff <= pair_in;
      end
   end

   // Even rows park their pair sums; the odd row below reads them back. The
   // write lands in the cycle after its beat, before the same column of the next
   // row can be accepted.
   always_ff @(posedge clock) begin
      if (s1_move && !s1_emit_ff) begin
         line_mem[s1_addr_ff] <= s1_pair_ff;
      end
      if (accept) begin
         line_rd_ff <= line_mem[col_ff[COL_W-1:1]];
      end
   end

   // ------------------------------------------------------------------------
   // Block average and output register
   // ------------------------------------------------------------------------
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         logic [PAIR_W:0] sum;
         sum = (PAIR_W + 1)'(line_rd_ff[c*PAIR_W +: PAIR_W])
             + (PAIR_W + 1)'(s1_pair_ff[c*PAIR_W +: PAIR_W]);
         rsp_data_in[c*CHAN_W +: CHAN_W] = sum[PAIR_W:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff && s1_emit_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

@@ hdl/rbd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_checker: port-level checks for the RGBA 2x2 box downscaler
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module rbd_checker
   import rbd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   input wire logic [PIXEL_W-1:0]    rsp_tdata,
   input wire logic                  rsp_tlast
);

   // Reset empties the output register.
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled beat keeps its contents.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // With the output register empty the stage register always drains.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // A fresh result follows an accepted request beat through the stage and output registers.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without matching request beat");

endmodule

bind rgba_2x2_box_downscaler rbd_checker u_rbd_checker (.*);
`default_nettype wire

@@ tb/rgba_2x2_box_downscaler_tb.sv @@
// ----------------------------------------------------------------------------
// rgba_2x2_box_downscaler_tb: self-checking bench for the 2x2 box downscaler
// Streams whole frames of RGBA pixels into the block and predicts every
// averaged output pixel with a line store of its own. Each output beat is
// checked field by field. The bench covers full-scale and zero channels,
// odd frame sizes, dimensions that saturate, a width change in the middle
// of a frame, and random frames under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module rgba_2x2_box_downscaler_tb;
   import rbd_pkg::*;

   localparam int MAX_W         = MAX_WIDTH_DEFAULT;
   localparam int LINE_DEPTH    = (MAX_W + 1) / 2;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PIXELS = 330;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct {
      pixel_type box;
      logic      frame_last;
   } box_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   rgba_2x2_box_downscaler #(
      .MAX_WIDTH (MAX_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Own copy of the block's registers and state.
   logic [CFG_W-1:0]  width_setting  = CFG_W'(WIDTH_RESET);
   logic [CFG_W-1:0]  height_setting = CFG_W'(HEIGHT_RESET);
   int                col_pos = 0;
   int                row_pos = 0;
   pixel_type         left_hold = '0;
   logic [PAIR_W-1:0] pair_line [LINE_DEPTH][CHANNELS];

   box_result_type expected_boxes [$];
   int             mismatch_count = 0;
   int             burst_left = 0;
   string          chan_names [CHANNELS] = '{"red", "green", "blue", "alpha"};

   function automatic int dim_limit(logic [CFG_W-1:0] raw, int hi);
      int v;
      v = int'(raw);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void predict_box_average(pixel_type p);
      int              w, h, ew, eh, idx;
      logic [PAIR_W-1:0] pair;
      logic [PAIR_W:0]   block_sum;
      pixel_type         avg;
      w  = dim_limit(width_setting, MAX_W);
      h  = dim_limit(height_setting, HEIGHT_MAX);
      ew = w & ~1;
      eh = h & ~1;
      avg = '0;
      // An odd last column or line never reaches this branch.
      if (col_pos < ew && row_pos < eh) begin
         if (col_pos % 2 == 0) begin
            left_hold = p;
         end else begin
            idx = (col_pos / 2) % LINE_DEPTH;
            for (int c = 0; c < CHANNELS; c++) begin
               pair = left_hold[CHAN_W*c +: CHAN_W] + p[CHAN_W*c +: CHAN_W];
               if (row_pos % 2 == 0) begin
                  pair_line[idx][c] = pair;
               end else begin
                  block_sum = pair_line[idx][c] + pair;
                  avg[CHAN_W*c +: CHAN_W] = block_sum[PAIR_W:2];
               end
            end
            if (row_pos % 2 == 1)
               expected_boxes.push_back('{box: avg,
                  frame_last: (col_pos == ew - 1 && row_pos == eh - 1)});
         end
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic logic [CHAN_W-1:0] rand_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p.red   = rand_channel();
      p.green = rand_channel();
      p.blue  = rand_channel();
      p.alpha = rand_channel();
      return p;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the beat.
   task automatic send_pixel(input pixel_type p);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      predict_box_average(p);
      burst_left--;
   endtask

   // Stops the input and waits until the block has nothing left in flight.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_WIDTH)
         width_setting = value;
      else
         height_setting = value;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      settle_idle();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic send_frame();
      int pixels;
      pixels = dim_limit(width_setting, MAX_W) * dim_limit(height_setting, HEIGHT_MAX);
      repeat (pixels) send_pixel(rand_pixel());
   endtask

   task automatic test_extreme_values();
      set_frame(CFG_W'(2), CFG_W'(2));
      repeat (4) send_pixel('1);
      repeat (4) send_pixel('0);
      // Sums just under a multiple of four show the truncation.
      send_pixel('{red: 8'd255, green: 8'd3, blue: 8'd1, alpha: 8'd0});
      send_pixel('{red: 8'd255, green: 8'd3, blue: 8'd1, alpha: 8'd255});
      send_pixel('{red: 8'd255, green: 8'd3, blue: 8'd1, alpha: 8'd0});
      send_pixel('{red: 8'd254, green: 8'd2, blue: 8'd0, alpha: 8'd255});
   endtask

   task automatic test_odd_dimensions();
      set_frame(CFG_W'(3), CFG_W'(3));
      send_frame();
   endtask

   task automatic test_width_change_mid_frame();
      set_frame(CFG_W'(8), CFG_W'(4));
      repeat (7) send_pixel(rand_pixel());
      // The column counter is already past the new width and wraps on the
      // next beat; the second line reads only pair sums of the first.
      settle_idle();
      write_reg(CSR_FRAME_WIDTH, CFG_W'(4));
      repeat (13) send_pixel(rand_pixel());
   endtask

   task automatic test_clamped_dimensions();
      set_frame(CFG_W'(0), CFG_W'(1));
      send_frame();
      // An oversized width saturates; a narrower width then wraps the
      // counter past its new limit and the second line completes two blocks.
      set_frame('1, CFG_W'(2));
      repeat (6) send_pixel(rand_pixel());
      settle_idle();
      write_reg(CSR_FRAME_WIDTH, CFG_W'(4));
      repeat (5) send_pixel(rand_pixel());
      // The same with an oversized height, closed by a shorter height.
      set_frame(CFG_W'(2), '1);
      repeat (8) send_pixel(rand_pixel());
      settle_idle();
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(2));
      repeat (2) send_pixel(rand_pixel());
   endtask

   task automatic test_random_frames();
      int sent;
      int w, h;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         // Some frames follow back to back with unchanged dimensions.
         if ($urandom_range(0, 2) != 0) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 10);
            h = $urandom_range(0, 8);
            set_frame(CFG_W'(w), CFG_W'(h));
         end
         sent += dim_limit(width_setting, MAX_W) * dim_limit(height_setting, HEIGHT_MAX);
         send_frame();
      end
   endtask

   // Output stall pattern: an 8-bit mask replayed until the 6-bit tick counter wraps.
   logic [7:0] stall_mask = 8'hFF;
   logic [5:0] stall_tick = '0;

   always @(posedge clock) begin
      if (stall_tick == 0)
         stall_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      rsp_tready <= stall_mask[stall_tick[2:0]];
      stall_tick <= stall_tick + 1'b1;
   end

   // Outputs are stable at the falling edge; the beat moves at the next rise.
   always @(negedge clock) begin
      box_result_type want;
      pixel_type      got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_boxes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected output beat, expected none, actual %h last %b",
                     $time, got, rsp_tlast);
         end else begin
            want = expected_boxes.pop_front();
            for (int c = 0; c < CHANNELS; c++) begin
               if (got[CHAN_W*c +: CHAN_W] !== want.box[CHAN_W*c +: CHAN_W]) begin
                  mismatch_count++;
                  $display("%0t: %s expected %0d actual %0d", $time, chan_names[c],
                           want.box[CHAN_W*c +: CHAN_W], got[CHAN_W*c +: CHAN_W]);
               end
            end
            if (rsp_tlast !== want.frame_last) begin
               mismatch_count++;
               $display("%0t: frame_last expected %b actual %b", $time,
                        want.frame_last, rsp_tlast);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_extreme_values();
      test_odd_dimensions();
      test_width_change_mid_frame();
      test_clamped_dimensions();
      test_random_frames();
      settle_idle();
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/rbd_pkg.sv
hdl/rgba_2x2_box_downscaler.sv
hdl/rbd_checker.sv
tb/rgba_2x2_box_downscaler_tb.sv
